// ===== rtl/core/clmfe_pkg.sv =====
// Shared types, codes and helpers of the color memory LCD frame engine.
`default_nettype none

package clmfe_pkg;

    // Default geometry of the frame store
    localparam int LINES_DEF      = 128;
    localparam int LINE_BYTES_DEF = 48;

    // Operation codes of a command word
    localparam logic [2:0] OP_WRITE_PIXEL  = 3'd0;
    localparam logic [2:0] OP_SEND_LINE    = 3'd1;
    localparam logic [2:0] OP_ALL_CLEAR    = 3'd2;
    localparam logic [2:0] OP_DISPLAY      = 3'd3;
    localparam logic [2:0] OP_CLEAR_BUFFER = 3'd4;

    // Panel command bytes
    localparam logic [7:0] CMD_UPDATE    = 8'h80;
    localparam logic [7:0] CMD_ALL_CLEAR = 8'h20;
    localparam logic [7:0] CMD_DUMMY     = 8'h00;

    // Command word
    typedef struct packed {
        logic [2:0] operation;
        logic [6:0] pixel_x;
        logic [6:0] pixel_y;
        logic [2:0] color;
        logic [7:0] line_number;
        logic       first_of_update;
        logic       last_of_update;
    } cmd_t;

    // Response word
    typedef struct packed {
        logic [7:0] spi_byte;
        logic       end_of_run;
    } rsp_t;

    // Mirror a byte, bit 0 to bit 7
    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/clmfe_chan_if.sv =====
// Valid/ready channel carrying one payload word.
`default_nettype none

interface clmfe_chan_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/clmfe_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module clmfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 6144,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/color_memory_lcd_frame_engine.sv =====
// Top level of the color memory LCD frame engine: frame store and line sequencer.
//
//   channel  dir  word   fields
//   cmd      in   cmd_t  operation, pixel_x, pixel_y, color, line_number,
//                        first_of_update, last_of_update
//   rsp      out  rsp_t  spi_byte, end_of_run
//
// Write pixel: a read-modify-write of one byte, or two when the pixel spans
// two bytes, through the registered-read frame store RAM. Send line emits
// LINE_BYTES + 2 to LINE_BYTES + 4 bytes, paced by the output register. All
// clear and display emit a command byte and a dummy byte. Clear buffer zeroes
// the store; after reset a clearing pass over it (6144 bytes by default) runs
// with cmd.ready low. A stalled rsp holds the output states; cmd is taken only idle.
`default_nettype none

module color_memory_lcd_frame_engine
    import clmfe_pkg::*;
#(
    parameter int LINES      = LINES_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    clmfe_chan_if.sink   cmd,
    clmfe_chan_if.source rsp
);

    localparam int DEPTH  = LINES * LINE_BYTES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = ADDR_W + 8;
    localparam int CNT_W  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_PX0   = 4'd2;
    localparam logic [3:0] ST_PX1   = 4'd3;
    localparam logic [3:0] ST_CMD   = 4'd4;
    localparam logic [3:0] ST_ADDR  = 4'd5;
    localparam logic [3:0] ST_DATA  = 4'd6;
    localparam logic [3:0] ST_TAIL  = 4'd7;
    localparam logic [3:0] ST_TAIL2 = 4'd8;
    localparam logic [3:0] ST_PAIR0 = 4'd9;
    localparam logic [3:0] ST_PAIR1 = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;     // clear pointer, pixel or line address
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        line_reg, line_next;
    logic              last_reg, last_next;
    logic [2:0]        off_reg, off_next;
    logic [2:0]        color_reg, color_next;
    logic              wr0_ok_reg, wr0_ok_next;
    logic              wr1_ok_reg, wr1_ok_next;
    logic [7:0]        pair_byte_reg, pair_byte_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_eor_reg, out_eor_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [7:0]        load_byte;
    logic              load_eor;

    logic [8:0]        bitpos;
    logic [5:0]        byte_i;
    logic [SUM_W-1:0]  px_addr;
    logic [SUM_W-1:0]  line_base;
    logic              row_ok;
    logic              line_ok;
    logic [7:0]        c8;
    logic [7:0]        byte0;
    logic [7:0]        byte1;

    // Frame store
    clmfe_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Locate the pixel and the line in the store
    assign bitpos    = {1'b0, cmd.data.pixel_x, 1'b0} + {2'b00, cmd.data.pixel_x};
    assign byte_i    = bitpos[8:3];
    assign px_addr   = SUM_W'(cmd.data.pixel_y) * SUM_W'(LINE_BYTES) + SUM_W'(byte_i);
    assign line_base = SUM_W'(cmd.data.line_number - 8'd1) * SUM_W'(LINE_BYTES);
    assign row_ok    = {2'b00, cmd.data.pixel_y} < 9'(LINES);
    assign line_ok   = (cmd.data.line_number != 8'd0) &&
                       ({1'b0, cmd.data.line_number} <= 9'(LINES));

    // Merge the color into the old bytes
    assign c8    = {color_reg, 5'b00000};
    assign byte0 = (ram_rdata & ~(8'hE0 >> off_reg)) | (c8 >> off_reg);
    assign byte1 = (ram_rdata & (8'hFF >> (off_reg - 3'd5))) |
                   (c8 << (4'd8 - {1'b0, off_reg}));

    // Sequence operations
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        line_next      = line_reg;
        last_next      = last_reg;
        off_next       = off_reg;
        color_next     = color_reg;
        wr0_ok_next    = wr0_ok_reg;
        wr1_ok_next    = wr1_ok_reg;
        pair_byte_next = pair_byte_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = 8'h00;
        ram_re         = 1'b0;
        ram_raddr      = addr_reg;
        out_load       = 1'b0;
        load_byte      = CMD_DUMMY;
        load_eor       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = px_addr[ADDR_W-1:0];
                if (accept)
                begin
                    case (cmd.data.operation)
                        OP_WRITE_PIXEL:
                        begin
                            if (row_ok)
                            begin
                                ram_re      = 1'b1;
                                addr_next   = px_addr[ADDR_W-1:0];
                                off_next    = bitpos[2:0];
                                color_next  = cmd.data.color;
                                wr0_ok_next = {1'b0, byte_i} < 7'(LINE_BYTES);
                                wr1_ok_next = (bitpos[2:0] > 3'd5) &&
                                              ({1'b0, byte_i} + 7'd1 < 7'(LINE_BYTES));
                                state_next  = ST_PX0;
                            end
                        end
                        OP_SEND_LINE:
                        begin
                            if (line_ok)
                            begin
                                addr_next  = line_base[ADDR_W-1:0];
                                line_next  = cmd.data.line_number;
                                last_next  = cmd.data.last_of_update;
                                state_next = cmd.data.first_of_update ? ST_CMD : ST_ADDR;
                            end
                        end
                        OP_ALL_CLEAR:
                        begin
                            pair_byte_next = CMD_ALL_CLEAR;
                            state_next     = ST_PAIR0;
                        end
                        OP_DISPLAY:
                        begin
                            pair_byte_next = CMD_DUMMY;
                            state_next     = ST_PAIR0;
                        end
                        OP_CLEAR_BUFFER:
                        begin
                            addr_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = 8'h00;
                if (addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            ST_PX0:
            begin
                // write the first byte, fetch the second
                ram_we    = wr0_ok_reg;
                ram_wdata = byte0;
                ram_re    = wr1_ok_reg;
                ram_raddr = addr_reg + ADDR_W'(1);
                if (wr1_ok_reg)
                begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    state_next = ST_PX1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PX1:
            begin
                ram_we     = 1'b1;
                ram_wdata  = byte1;
                state_next = ST_IDLE;
            end
            ST_CMD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_byte  = CMD_UPDATE;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                // emit the gate address and fetch the first line byte
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_byte  = rev8(line_reg);
                    ram_re     = 1'b1;
                    addr_next  = addr_reg + ADDR_W'(1);
                    cnt_next   = '0;
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    load_byte = ram_rdata;
                    if (cnt_reg == CNT_W'(LINE_BYTES - 1))
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        addr_next = addr_reg + ADDR_W'(1);
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_TAIL:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_byte  = CMD_DUMMY;
                    load_eor   = !last_reg;
                    state_next = last_reg ? ST_TAIL2 : ST_IDLE;
                end
            end
            ST_TAIL2:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_byte  = CMD_DUMMY;
                    load_eor   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PAIR0:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_byte  = pair_byte_reg;
                    state_next = ST_PAIR1;
                end
            end
            ST_PAIR1:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_byte  = CMD_DUMMY;
                    load_eor   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Load or drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_eor_next   = out_eor_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = load_byte;
            out_eor_next   = load_eor;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers, reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        line_reg      <= line_next;
        last_reg      <= last_next;
        off_reg       <= off_next;
        color_reg     <= color_next;
        wr0_ok_reg    <= wr0_ok_next;
        wr1_ok_reg    <= wr1_ok_next;
        pair_byte_reg <= pair_byte_next;
        out_byte_reg  <= out_byte_next;
        out_eor_reg   <= out_eor_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.data.spi_byte   = out_byte_reg;
    assign rsp.data.end_of_run = out_eor_reg;

    // Store writes stay inside the store
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_waddr) < DEPTH))
    else $error("frame store write beyond its depth");

    // No store write while a line is being read out
    a_no_write_on_send: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADDR || state_reg == ST_DATA) |-> !ram_we)
    else $error("frame store written during a line send");

    // Byte counter stays inside the line
    a_cnt_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> (32'(cnt_reg) < LINE_BYTES))
    else $error("line byte counter past the end of the line");

    // Second byte of a pixel write ends the write
    a_px_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PX1) |=> (state_reg == ST_IDLE))
    else $error("pixel write did not return to idle");

    // A stalled response word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(out_byte_reg)))
    else $error("stalled response word changed");

endmodule

`default_nettype wire
